// ----- rtl/kcl_pkg.sv -----
// kcl_pkg: shared types and constants for the keypad code lock
// no dependencies; imported by the interfaces and the core
`default_nettype none

package kcl_pkg;

    // field widths of the item, result and configuration channels
    localparam int KEY_W      = 4;
    localparam int PW_W       = 24;
    localparam int ATTEMPT_W  = 4;
    localparam int TIMER_W    = 16;
    localparam int BLINK_W    = 8;
    localparam int ENTERED_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [PW_W-1:0]      PASSWORD_RST    = 24'h682A62;
    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPT_RST = 4'd3;
    localparam logic [TIMER_W-1:0]   HOLD_RST        = 16'd5000;
    localparam logic [TIMER_W-1:0]   BLINK_HALF_RST  = 16'd500;
    localparam logic [BLINK_W-1:0]   LOCK_BLINKS_RST = 8'd15;

    // key and counter limits
    localparam logic [KEY_W-1:0]     SUBMIT_KEY = 4'd14;
    localparam logic [ATTEMPT_W-1:0] FAIL_MAX   = 4'd15;

    // item kinds
    typedef enum logic
    {
        MODE_TICK = 1'b0,
        MODE_KEY  = 1'b1
    } mode_t;

    // lock phases, as reported on the result channel
    typedef enum logic [1:0]
    {
        PH_ENTRY  = 2'd0,
        PH_GRANT  = 2'd1,
        PH_REJECT = 2'd2,
        PH_LOCK   = 2'd3
    } phase_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_PASSWORD    = 3'd0,
        CFG_MAX_ATTEMPT = 3'd1,
        CFG_HOLD        = 3'd2,
        CFG_BLINK_HALF  = 3'd3,
        CFG_LOCK_BLINKS = 3'd4
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/kcl_ifs.sv -----
// kcl_ifs: valid/ready channel interfaces for the keypad code lock
// depends on kcl_pkg for field widths
`default_nettype none

// input item channel: tick or key transaction
interface kcl_item_if
    import kcl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output mode, output key_code, input ready);
    modport sink   (input valid, input mode, input key_code, output ready);
endinterface

// result channel: one transaction per accepted item
interface kcl_result_if
    import kcl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 green_led;
    logic                 red_led;
    logic [1:0]           phase;
    logic [ENTERED_W-1:0] entered_count;
    logic [ATTEMPT_W-1:0] attempts;

    modport source (output valid, output green_led, output red_led, output phase,
                    output entered_count, output attempts, input ready);
    modport sink   (input valid, input green_led, input red_led, input phase,
                    input entered_count, input attempts, output ready);
endinterface

// configuration write channel
interface kcl_cfg_if
    import kcl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/keypad_code_lock_core.sv -----
// keypad_code_lock_core: keypad lock state machine with registered result
// depends on kcl_pkg and the channel interfaces in kcl_ifs.sv
//
// result: registered, and valid in the cycle after its item is accepted
// throughput: one item per cycle; the result register is the only stage, and
// a new item is taken whenever that register is empty or being drained
// reset: phase entry, counts and timers zero, registers at their defaults;
// the entry buffer is not cleared (only slots already written are compared)
`default_nettype none

module keypad_code_lock_core
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = 6
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    kcl_cfg_if.sink       cfg,
    kcl_item_if.sink      item_in,
    kcl_result_if.source  result_out
);

    localparam int CNT_W  = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W  = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int PWX_W  = (KEY_W * CODE_LENGTH > PW_W) ? KEY_W * CODE_LENGTH : PW_W;
    localparam logic [CNT_W-1:0] CODE_LEN_CNT = CNT_W'(CODE_LENGTH);

    // configuration registers
    logic [PW_W-1:0]      password_reg;
    logic [ATTEMPT_W-1:0] max_attempt_reg;
    logic [TIMER_W-1:0]   hold_reg;
    logic [TIMER_W-1:0]   blink_half_reg;
    logic [BLINK_W-1:0]   lock_blinks_reg;

    // lock state
    phase_t               phase_reg,       phase_next;
    logic [KEY_W-1:0]     entry_buf_reg [CODE_LENGTH];
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic [ATTEMPT_W-1:0] fail_count_reg,  fail_count_next;
    logic [TIMER_W-1:0]   tick_timer_reg,  tick_timer_next;
    logic [BLINK_W-1:0]   blink_count_reg, blink_count_next;
    logic                 blink_on_reg,    blink_on_next;

    // result register
    logic                 out_valid_reg;
    logic                 green_reg,       green_next;
    logic                 red_reg,         red_next;
    phase_t               out_phase_reg;
    logic [ENTERED_W-1:0] out_entered_reg;
    logic [ATTEMPT_W-1:0] out_attempts_reg;

    logic                 in_ready;
    logic                 item_accept;
    logic                 key_store;
    logic                 code_match;
    logic [PWX_W-1:0]     password_ext;
    logic [TIMER_W-1:0]   hold_load;
    logic [TIMER_W-1:0]   blink_half_load;
    logic [BLINK_W-1:0]   lock_blinks_load;
    logic [TIMER_W-1:0]   timer_dec;
    logic [BLINK_W-1:0]   blink_dec;

    // handshakes
    assign cfg.ready     = 1'b1;
    assign in_ready      = !out_valid_reg || result_out.ready;
    assign item_in.ready = in_ready;
    assign item_accept   = item_in.valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            password_reg    <= PASSWORD_RST;
            max_attempt_reg <= MAX_ATTEMPT_RST;
            hold_reg        <= HOLD_RST;
            blink_half_reg  <= BLINK_HALF_RST;
            lock_blinks_reg <= LOCK_BLINKS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_PASSWORD:    password_reg    <= cfg.data[PW_W-1:0];
                CFG_MAX_ATTEMPT: max_attempt_reg <= cfg.data[ATTEMPT_W-1:0];
                CFG_HOLD:        hold_reg        <= cfg.data[TIMER_W-1:0];
                CFG_BLINK_HALF:  blink_half_reg  <= cfg.data[TIMER_W-1:0];
                CFG_LOCK_BLINKS: lock_blinks_reg <= cfg.data[BLINK_W-1:0];
                default:         ;
            endcase
        end
    end

    // zero-valued timing registers count as one
    assign hold_load        = (hold_reg == '0)        ? TIMER_W'(1) : hold_reg;
    assign blink_half_load  = (blink_half_reg == '0)  ? TIMER_W'(1) : blink_half_reg;
    assign lock_blinks_load = (lock_blinks_reg == '0) ? BLINK_W'(1) : lock_blinks_reg;
    assign timer_dec        = (tick_timer_reg == '0) ? '0 : tick_timer_reg - TIMER_W'(1);
    assign blink_dec        = (blink_count_reg == '0) ? '0 : blink_count_reg - BLINK_W'(1);

    // password compare; nibbles beyond the register compare against zero
    assign password_ext = PWX_W'(password_reg);

    always_comb
    begin
        code_match = (entry_count_reg == CODE_LEN_CNT);
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (entry_buf_reg[i] != password_ext[KEY_W*i +: KEY_W])
            begin
                code_match = 1'b0;
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        entry_count_next = entry_count_reg;
        fail_count_next  = fail_count_reg;
        tick_timer_next  = tick_timer_reg;
        blink_count_next = blink_count_reg;
        blink_on_next    = blink_on_reg;
        key_store        = 1'b0;

        if (mode_t'(item_in.mode) == MODE_KEY)
        begin
            if (phase_reg == PH_ENTRY)
            begin
                if (item_in.key_code == SUBMIT_KEY)
                begin
                    if (code_match)
                    begin
                        phase_next      = PH_GRANT;
                        fail_count_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_REJECT;
                        if (fail_count_reg < FAIL_MAX)
                        begin
                            fail_count_next = fail_count_reg + ATTEMPT_W'(1);
                        end
                    end
                    tick_timer_next  = hold_load;
                    entry_count_next = '0;
                end
                else if (entry_count_reg < CODE_LEN_CNT)
                begin
                    key_store        = 1'b1;
                    entry_count_next = entry_count_reg + CNT_W'(1);
                end
            end
        end
        else if (phase_reg != PH_ENTRY)
        begin
            tick_timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                case (phase_reg)
                    PH_GRANT:
                    begin
                        phase_next = PH_ENTRY;
                    end
                    PH_REJECT:
                    begin
                        if (fail_count_reg >= max_attempt_reg)
                        begin
                            phase_next       = PH_LOCK;
                            blink_count_next = lock_blinks_load;
                            blink_on_next    = 1'b1;
                            tick_timer_next  = blink_half_load;
                        end
                        else
                        begin
                            phase_next = PH_ENTRY;
                        end
                    end
                    PH_LOCK:
                    begin
                        if (blink_on_reg)
                        begin
                            blink_on_next   = 1'b0;
                            tick_timer_next = blink_half_load;
                        end
                        else
                        begin
                            blink_count_next = blink_dec;
                            if (blink_dec == '0)
                            begin
                                fail_count_next = '0;
                                phase_next      = PH_ENTRY;
                            end
                            else
                            begin
                                blink_on_next   = 1'b1;
                                tick_timer_next = blink_half_load;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // light outputs from the next state
    always_comb
    begin
        green_next = 1'b0;
        red_next   = 1'b0;
        case (phase_next)
            PH_GRANT:  green_next = 1'b1;
            PH_REJECT: red_next   = 1'b1;
            PH_LOCK:   red_next   = blink_on_next;
            default:   ;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_ENTRY;
            entry_count_reg <= '0;
            fail_count_reg  <= '0;
            tick_timer_reg  <= '0;
            blink_count_reg <= '0;
            blink_on_reg    <= 1'b0;
        end
        else if (item_accept)
        begin
            phase_reg       <= phase_next;
            entry_count_reg <= entry_count_next;
            fail_count_reg  <= fail_count_next;
            tick_timer_reg  <= tick_timer_next;
            blink_count_reg <= blink_count_next;
            blink_on_reg    <= blink_on_next;
        end
    end

    // entry buffer, written at the current fill position
    always_ff @(posedge clk)
    begin
        if (item_accept && key_store)
        begin
            entry_buf_reg[entry_count_reg[IDX_W-1:0]] <= item_in.key_code;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= item_in.valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            green_reg        <= green_next;
            red_reg          <= red_next;
            out_phase_reg    <= phase_next;
            out_entered_reg  <= ENTERED_W'(entry_count_next);
            out_attempts_reg <= fail_count_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.green_led     = green_reg;
    assign result_out.red_led       = red_reg;
    assign result_out.phase         = out_phase_reg;
    assign result_out.entered_count = out_entered_reg;
    assign result_out.attempts      = out_attempts_reg;

    // entry buffer never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CODE_LEN_CNT)
        else $error("entry count beyond code length");

    // the buffer is emptied by submit and keys are ignored outside entry
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_ENTRY |-> entry_count_reg == '0)
        else $error("keys held outside entry");

    // a grant always clears the failure count
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_GRANT |-> fail_count_reg == '0)
        else $error("failure count set while granted");

    // lockout always has blinks left to run
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LOCK |-> blink_count_reg != '0)
        else $error("lockout with no blinks left");

    // every accepted item leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> out_valid_reg)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire

// ----- dv/kcl_lock_checker.sv -----
// kcl_lock_checker: watches the config, item and result channels of the lock core
// keeps its own copy of the lock state and compares each result transaction
// depends on kcl_pkg and the channel interfaces in kcl_ifs.sv
`default_nettype none

module kcl_lock_checker
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = 6,
    parameter int REPORT_MAX  = 10
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    kcl_cfg_if        cfg_bus,
    kcl_item_if       item_bus,
    kcl_result_if     result_bus,
    output int        mismatches,
    output int        outstanding
);

    // what the lock shows after one transaction
    typedef struct packed
    {
        logic                 green_led;
        logic                 red_led;
        phase_t               phase;
        logic [ENTERED_W-1:0] entered_count;
        logic [ATTEMPT_W-1:0] attempts;
    } panel_t;

    // register shadows
    logic [PW_W-1:0]      pw_reg;
    logic [ATTEMPT_W-1:0] max_reg;
    logic [TIMER_W-1:0]   hold_reg;
    logic [TIMER_W-1:0]   half_reg;
    logic [BLINK_W-1:0]   blinks_reg;

    // lock state
    phase_t               lk_phase;
    logic [KEY_W-1:0]     keys_held [CODE_LENGTH];
    int                   held_n;
    logic [ATTEMPT_W-1:0] fails;
    logic [TIMER_W-1:0]   timer;
    logic [BLINK_W-1:0]   blinks_left;
    logic                 lamp_on;

    panel_t expected_panels [$];
    panel_t got;
    panel_t want;
    int     bad_total;

    // zero timer settings count as one tick
    function automatic logic [TIMER_W-1:0] at_least_one(logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

    // apply one tick or key to the lock state and return what it then shows
    function automatic panel_t advance_lock(mode_t kind, logic [KEY_W-1:0] key);
        panel_t shown;
        bit     hit;
        int     i;
        if (kind == MODE_KEY)
        begin
            if (lk_phase == PH_ENTRY)
            begin
                if (key == SUBMIT_KEY)
                begin
                    // a match needs a full entry equal to every nibble
                    hit = (held_n == CODE_LENGTH);
                    for (i = 0; i < CODE_LENGTH; i++)
                        if (keys_held[i] !== pw_reg[4*i +: KEY_W])
                            hit = 1'b0;
                    if (hit)
                    begin
                        lk_phase = PH_GRANT;
                        fails    = '0;
                    end
                    else
                    begin
                        lk_phase = PH_REJECT;
                        if (fails != FAIL_MAX)
                            fails = fails + 1'b1;
                    end
                    timer  = at_least_one(hold_reg);
                    held_n = 0;
                end
                else if (held_n < CODE_LENGTH)
                begin
                    keys_held[held_n] = key;
                    held_n++;
                end
            end
        end
        else if (lk_phase != PH_ENTRY)
        begin
            if (timer != '0)
                timer = timer - 1'b1;
            if (timer == '0)
            begin
                case (lk_phase)
                    PH_GRANT:
                    begin
                        lk_phase = PH_ENTRY;
                    end
                    PH_REJECT:
                    begin
                        if (fails >= max_reg)
                        begin
                            lk_phase    = PH_LOCK;
                            blinks_left = (blinks_reg == '0) ? BLINK_W'(1) : blinks_reg;
                            lamp_on     = 1'b1;
                            timer       = at_least_one(half_reg);
                        end
                        else
                        begin
                            lk_phase = PH_ENTRY;
                        end
                    end
                    default:
                    begin
                        // lockout blink: on half, then off half, then next blink
                        if (lamp_on)
                        begin
                            lamp_on = 1'b0;
                            timer   = at_least_one(half_reg);
                        end
                        else
                        begin
                            if (blinks_left != '0)
                                blinks_left = blinks_left - 1'b1;
                            if (blinks_left == '0)
                            begin
                                fails    = '0;
                                lk_phase = PH_ENTRY;
                            end
                            else
                            begin
                                lamp_on = 1'b1;
                                timer   = at_least_one(half_reg);
                            end
                        end
                    end
                endcase
            end
        end
        shown.green_led     = (lk_phase == PH_GRANT);
        shown.red_led       = (lk_phase == PH_REJECT) || ((lk_phase == PH_LOCK) && lamp_on);
        shown.phase         = lk_phase;
        shown.entered_count = ENTERED_W'(held_n);
        shown.attempts      = fails;
        return shown;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg      = PASSWORD_RST;
            max_reg     = MAX_ATTEMPT_RST;
            hold_reg    = HOLD_RST;
            half_reg    = BLINK_HALF_RST;
            blinks_reg  = LOCK_BLINKS_RST;
            lk_phase    = PH_ENTRY;
            held_n      = 0;
            fails       = '0;
            timer       = '0;
            blinks_left = '0;
            lamp_on     = 1'b0;
            foreach (keys_held[j])
                keys_held[j] = '0;
            expected_panels.delete();
            bad_total   = 0;
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // result side first: its expectation was queued at an earlier edge
            if (result_bus.valid && result_bus.ready)
            begin
                got.green_led     = result_bus.green_led;
                got.red_led       = result_bus.red_led;
                got.phase         = phase_t'(result_bus.phase);
                got.entered_count = result_bus.entered_count;
                got.attempts      = result_bus.attempts;
                if (expected_panels.size() == 0)
                begin
                    if (bad_total < REPORT_MAX)
                        $display("[%0t] result transaction with nothing pending: g=%0b r=%0b ph=%0d n=%0d att=%0d",
                                 $realtime, got.green_led, got.red_led, got.phase,
                                 got.entered_count, got.attempts);
                    bad_total++;
                end
                else
                begin
                    want = expected_panels.pop_front();
                    if ((got.green_led !== want.green_led) || (got.red_led !== want.red_led) ||
                        (got.phase !== want.phase) ||
                        (got.entered_count !== want.entered_count) ||
                        (got.attempts !== want.attempts))
                    begin
                        if (bad_total < REPORT_MAX)
                            $display("[%0t] result mismatch: expected g=%0b r=%0b ph=%0d n=%0d att=%0d, got g=%0b r=%0b ph=%0d n=%0d att=%0d",
                                     $realtime, want.green_led, want.red_led, want.phase,
                                     want.entered_count, want.attempts, got.green_led,
                                     got.red_led, got.phase, got.entered_count, got.attempts);
                        bad_total++;
                    end
                end
            end

            // register writes
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_idx_t'(cfg_bus.index))
                    CFG_PASSWORD:    pw_reg     = cfg_bus.data[PW_W-1:0];
                    CFG_MAX_ATTEMPT: max_reg    = cfg_bus.data[ATTEMPT_W-1:0];
                    CFG_HOLD:        hold_reg   = cfg_bus.data[TIMER_W-1:0];
                    CFG_BLINK_HALF:  half_reg   = cfg_bus.data[TIMER_W-1:0];
                    CFG_LOCK_BLINKS: blinks_reg = cfg_bus.data[BLINK_W-1:0];
                    default:         ;
                endcase
            end

            // accepted tick or key
            if (item_bus.valid && item_bus.ready)
                expected_panels.push_back(advance_lock(mode_t'(item_bus.mode), item_bus.key_code));

            outstanding <= expected_panels.size();
            mismatches  <= bad_total;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb_keypad_code_lock_core.sv -----
// tb_keypad_code_lock_core: stimulus, clock, reset and verdict for the lock core
// depends on kcl_pkg, kcl_ifs.sv, keypad_code_lock_core and kcl_lock_checker
`default_nettype none

module tb_keypad_code_lock_core;
    import kcl_pkg::*;

    localparam int LIMIT     = 2_000_000;
    localparam int LONG_HOLD = 300;
    localparam int CODE_KEYS = PW_W / KEY_W;

    logic clk;
    logic rst_n;
    int   cycles;
    int   mismatches;
    int   outstanding;
    int   items_sent;
    int   tick_span;
    bit   steady_send;
    bit   steady_drain;
    bit   long_hold_req;
    logic [PW_W-1:0] cur_pw;

    kcl_cfg_if    cfg_bus ();
    kcl_item_if   item_bus ();
    kcl_result_if result_bus ();

    keypad_code_lock_core u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .item_in    (item_bus),
        .result_out (result_bus)
    );

    kcl_lock_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_bus     (cfg_bus),
        .item_bus    (item_bus),
        .result_bus  (result_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // any key except submit
    function automatic logic [KEY_W-1:0] plain_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom_range(0, 14));
        return (k == SUBMIT_KEY) ? 4'hF : k;
    endfunction

    // password that can be typed in full
    function automatic logic [PW_W-1:0] clean_code();
        logic [PW_W-1:0] code;
        int              slot;
        for (slot = 0; slot < CODE_KEYS; slot++)
            code[4*slot +: KEY_W] = plain_key();
        return code;
    endfunction

    // result drain, with random stalls and the long hold-off on request
    initial
    begin : drain
        int stall;
        result_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall = pick_gap(steady_drain);
                if (stall > 0)
                begin
                    result_bus.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result_bus.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // one config write transaction
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // one item transaction, followed by a random gap
    task automatic offer_item(mode_t kind, logic [KEY_W-1:0] key);
        int gap;
        item_bus.valid    <= 1'b1;
        item_bus.mode     <= kind;
        item_bus.key_code <= key;
        do @(posedge clk); while (!item_bus.ready);
        items_sent++;
        gap = pick_gap(steady_send);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every pending result
    task automatic drain_wait(int extra);
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // write every register; only called while idle
    task automatic apply_settings(logic [PW_W-1:0] pw, logic [ATTEMPT_W-1:0] max_fail,
                                  logic [TIMER_W-1:0] hold, logic [TIMER_W-1:0] half,
                                  logic [BLINK_W-1:0] blinks);
        int h;
        int b;
        int n;
        drain_wait(4);
        write_reg(CFG_PASSWORD, pw);
        write_reg(CFG_MAX_ATTEMPT, CFG_DATA_W'(max_fail));
        write_reg(CFG_HOLD, CFG_DATA_W'(hold));
        write_reg(CFG_BLINK_HALF, CFG_DATA_W'(half));
        write_reg(CFG_LOCK_BLINKS, CFG_DATA_W'(blinks));
        cur_pw = pw;
        h = (hold == '0) ? 1 : int'(hold);
        b = (half == '0) ? 1 : int'(half);
        n = (blinks == '0) ? 1 : int'(blinks);
        tick_span = h + 2 * b * n + 3;
    endtask

    // keys from the code nibbles, random keys past the code length
    task automatic press_keys(logic [PW_W-1:0] code, int count);
        int slot;
        for (slot = 0; slot < count; slot++)
        begin
            if (slot < CODE_KEYS)
                offer_item(MODE_KEY, code[4*slot +: KEY_W]);
            else
                offer_item(MODE_KEY, plain_key());
        end
    endtask

    task automatic tick_burst(int count);
        repeat (count) offer_item(MODE_TICK, KEY_W'($urandom));
    endtask

    // back-to-back ticks with no idling on either side
    task automatic bulk_ticks(int count);
        steady_send  = 1'b1;
        steady_drain = 1'b1;
        tick_burst(count);
        steady_send  = 1'b0;
        steady_drain = 1'b0;
    endtask

    // mostly well-formed entries with random content, some noise
    task automatic random_traffic(int budget, bit squeeze, bit pause_mid);
        int              stop_at;
        int              half_at;
        int              pick;
        int              slot;
        bit              done_mid;
        logic [PW_W-1:0] code;
        stop_at  = items_sent + budget;
        half_at  = items_sent + budget / 2;
        done_mid = 1'b0;
        while (items_sent < stop_at)
        begin
            if (!done_mid && items_sent >= half_at)
            begin
                done_mid = 1'b1;
                if (squeeze)
                    long_hold_req = 1'b1;
                if (pause_mid)
                    drain_wait($urandom_range(1, 20));
            end
            if ($urandom_range(0, 19) == 0)
                steady_send = !steady_send;
            if ($urandom_range(0, 19) == 0)
                steady_drain = !steady_drain;
            pick = $urandom_range(0, 99);
            code = cur_pw;
            if (pick < 40)
            begin
                press_keys(code, CODE_KEYS);
                offer_item(MODE_KEY, SUBMIT_KEY);
            end
            else if (pick < 70)
            begin
                // one nibble wrong
                slot = $urandom_range(0, CODE_KEYS - 1);
                code[4*slot +: KEY_W] = code[4*slot +: KEY_W] ^ KEY_W'($urandom_range(1, 15));
                press_keys(code, CODE_KEYS);
                offer_item(MODE_KEY, SUBMIT_KEY);
            end
            else if (pick < 85)
            begin
                // random entry: empty, short, full-length or overlong
                code = PW_W'($urandom);
                press_keys(code, $urandom_range(0, CODE_KEYS + 2));
                offer_item(MODE_KEY, SUBMIT_KEY);
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                    offer_item(mode_t'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 15)));
            end
            tick_burst($urandom_range(0, tick_span));
        end
        steady_send  = 1'b0;
        steady_drain = 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n             = 1'b0;
        items_sent        = 0;
        steady_send       = 1'b0;
        steady_drain      = 1'b0;
        long_hold_req     = 1'b0;
        cur_pw            = PASSWORD_RST;
        tick_span         = 8;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_PASSWORD;
        cfg_bus.data      <= '0;
        item_bus.valid    <= 1'b0;
        item_bus.mode     <= MODE_TICK;
        item_bus.key_code <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset password grants with a short hold; key while granting is ignored
        write_reg(CFG_HOLD, CFG_DATA_W'(16'd3));
        tick_burst(1);
        press_keys(cur_pw, CODE_KEYS);
        offer_item(MODE_KEY, SUBMIT_KEY);
        offer_item(MODE_KEY, 4'h5);
        bulk_ticks(5);

        // empty entry, short entry into lockout, overlong entry with dropped key
        apply_settings(clean_code(), 4'd2, 16'd2, 16'd1, 8'd2);
        offer_item(MODE_KEY, SUBMIT_KEY);
        offer_item(MODE_KEY, 4'h3);
        tick_burst(2);
        offer_item(MODE_KEY, 4'h0);
        offer_item(MODE_KEY, 4'hF);
        offer_item(MODE_KEY, 4'h1);
        offer_item(MODE_KEY, SUBMIT_KEY);
        tick_burst(7);
        press_keys(cur_pw, CODE_KEYS + 1);
        offer_item(MODE_KEY, SUBMIT_KEY);
        tick_burst(3);

        // random phases over several settings
        apply_settings(clean_code(), ATTEMPT_W'($urandom_range(1, 4)),
                       TIMER_W'($urandom_range(1, 4)), TIMER_W'($urandom_range(1, 3)),
                       BLINK_W'($urandom_range(1, 3)));
        random_traffic(130, 1'b1, 1'b0);

        apply_settings(24'h000000, 4'd15, 16'd1, 16'd1, 8'd1);
        random_traffic(180, 1'b0, 1'b1);

        // zero settings count as one; zero max locks out on every reject
        apply_settings(24'hFFFFFF, 4'd0, 16'd0, 16'd0, 8'd0);
        random_traffic(110, 1'b0, 1'b0);

        apply_settings(PW_W'($urandom), ATTEMPT_W'($urandom_range(1, 3)),
                       TIMER_W'($urandom_range(1, 3)), TIMER_W'($urandom_range(1, 2)),
                       BLINK_W'($urandom_range(1, 2)));
        random_traffic(130, 1'b1, 1'b1);

        // full lockout run with back-to-back ticks
        apply_settings(clean_code(), 4'd1, 16'd1, 16'd1, 8'd6);
        offer_item(MODE_KEY, SUBMIT_KEY);
        bulk_ticks(2 * 6 + 4);
        apply_settings(clean_code(), 4'd2, 16'd3, 16'd2, 8'd2);
        random_traffic(110, 1'b0, 1'b0);

        // largest timing settings load without wrapping; the hold is still counting at the end
        apply_settings(24'hFFFFFF, 4'd1, 16'hFFFF, 16'hFFFF, 8'd255);
        press_keys(24'hFFFFFF, CODE_KEYS - 1);
        offer_item(MODE_KEY, SUBMIT_KEY);
        bulk_ticks(24);

        drain_wait(8);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
